// ===== hw/rtl/brle_pkg.sv =====
// ----------------------------------------------------------------------------
// brle_pkg
// Shared types and constants of the byte run-length decoder.
// ----------------------------------------------------------------------------
package brle_pkg;

   localparam int SLOT_COUNT       = 4;
   localparam int BYTES_PER_RESULT = 4;
   localparam int PACK_WIDTH       = (BYTES_PER_RESULT < 1) ? 1 :
                                     (BYTES_PER_RESULT > SLOT_COUNT) ? SLOT_COUNT :
                                     BYTES_PER_RESULT;

   localparam int BYTE_W  = 8;
   localparam int RUN_W   = 7;
   localparam int COUNT_W = 3;

   localparam logic [BYTE_W-1:0] LITERAL_MASK = 8'h7f;

   localparam int RSP_PAYLOAD_W = SLOT_COUNT * BYTE_W + COUNT_W;
   localparam int RSP_DATA_W    = ((RSP_PAYLOAD_W + 7) / 8) * 8;

   typedef enum logic [0:0] {
      ST_ITEM,
      ST_EXPAND
   } state_type;

   typedef struct packed {
      logic load_item;
      logic load_chunk;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic expand_start;
      logic chunk_last;
   } status_type;

endpackage

// ===== hw/rtl/byte_rle_decoder.sv =====
// ----------------------------------------------------------------------------
// byte_rle_decoder
// Byte run-length decoder with packed result beats.
//
// The req_ channel carries one encoded byte per beat, with req_tlast on the
// final byte of a stream. A header byte above 127 opens a literal run of
// (header & 0x7f) bytes; any other header repeats the following byte that
// many times. The rsp_ channel carries up to four decoded bytes per beat with
// their count; rsp_tuser marks the final beat caused by an input byte and
// rsp_tlast marks that beat when the input byte ended the stream.
// A header or literal byte gives one result beat, available the cycle after
// the input beat is taken, so these stream at one byte per cycle while the receiver keeps up.
// A repeat data byte with count n gives ceil(n / 4) beats, at most 32, one per
// cycle while the receiver takes them; the controller holds req_tready low meanwhile.
// Reset puts the decoder in header mode with no result pending.
// When the receiver stalls, the result register holds its beat and req_tready
// falls until the result is taken.
// ----------------------------------------------------------------------------
module byte_rle_decoder import brle_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] in_byte
   input  logic                  req_tlast,   // last_in
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // byte_0, byte_1, byte_2, byte_3, byte_count
   output logic                  rsp_tuser,   // item_done
   output logic                  rsp_tlast    // stream_end
);

   cmd_type              cmd;
   status_type           status;
   logic [BYTE_W-1:0]    rsp_bytes [SLOT_COUNT];
   logic [COUNT_W-1:0]   rsp_count;

   brle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   brle_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .in_byte    (req_tdata),
      .last_in    (req_tlast),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_bytes  (rsp_bytes),
      .rsp_count  (rsp_count),
      .rsp_done   (rsp_tuser),
      .rsp_end    (rsp_tlast)
   );

   always_comb begin
      rsp_tdata = '0;
      for (int k = 0; k < SLOT_COUNT; k++) begin
         rsp_tdata[k*BYTE_W +: BYTE_W] = rsp_bytes[k];
      end
      rsp_tdata[SLOT_COUNT*BYTE_W +: COUNT_W] = rsp_count;
   end

endmodule

// ===== hw/rtl/brle_ctrl.sv =====
// ----------------------------------------------------------------------------
// brle_ctrl
// Controller: accepts encoded beats and sequences the chunks of a repeat run.
// ----------------------------------------------------------------------------
module brle_ctrl import brle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ITEM;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      cmd.load_item  = 1'b0;
      cmd.load_chunk = 1'b0;
      case (state_ff)
         ST_ITEM: begin
            req_tready    = status.out_free;
            cmd.load_item = req_tvalid && status.out_free;
            if (cmd.load_item && status.expand_start) begin
               state_in = ST_EXPAND;
            end
         end
         ST_EXPAND: begin
            cmd.load_chunk = status.out_free;
            if (status.out_free && status.chunk_last) begin
               state_in = ST_ITEM;
            end
         end
         default: begin
            state_in = ST_ITEM;
         end
      endcase
   end

endmodule

// ===== hw/rtl/brle_datapath.sv =====
// ----------------------------------------------------------------------------
// brle_datapath
// Decoder state, repeat counter and the registered result beat.
// ----------------------------------------------------------------------------
module brle_datapath import brle_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [BYTE_W-1:0]     in_byte,
   input  logic                  last_in,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  rsp_tready,
   output logic                  rsp_valid,
   output logic [BYTE_W-1:0]     rsp_bytes [SLOT_COUNT],
   output logic [COUNT_W-1:0]    rsp_count,
   output logic                  rsp_done,
   output logic                  rsp_end
);

   localparam logic [RUN_W-1:0] PACK_RUN = RUN_W'(PACK_WIDTH);

   logic                  expect_header_ff, expect_header_in;
   logic                  literal_mode_ff, literal_mode_in;
   logic [RUN_W-1:0]      run_left_ff, run_left_in;
   logic [RUN_W-1:0]      left_ff, left_in;
   logic [BYTE_W-1:0]     rep_byte_ff, rep_byte_in;
   logic                  rep_last_ff, rep_last_in;
   logic                  valid_ff, valid_in;
   logic [BYTE_W-1:0]     byte_ff [SLOT_COUNT];
   logic [BYTE_W-1:0]     byte_in [SLOT_COUNT];
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  done_ff, done_in;
   logic                  end_ff, end_in;

   logic [RUN_W-1:0]      item_take;
   logic [RUN_W-1:0]      chunk_take;
   logic [RUN_W-1:0]      literal_left;

   assign item_take    = (run_left_ff > PACK_RUN) ? PACK_RUN : run_left_ff;
   assign chunk_take   = (left_ff > PACK_RUN) ? PACK_RUN : left_ff;
   assign literal_left = (run_left_ff == '0) ? '0 : run_left_ff - 1'b1;

   assign status.out_free     = !valid_ff || rsp_tready;
   assign status.expand_start = !expect_header_ff && !literal_mode_ff &&
                                (run_left_ff > PACK_RUN);
   assign status.chunk_last   = (left_ff <= PACK_RUN);

   always_comb begin
      expect_header_in = expect_header_ff;
      literal_mode_in  = literal_mode_ff;
      run_left_in      = run_left_ff;
      left_in          = left_ff;
      rep_byte_in      = rep_byte_ff;
      rep_last_in      = rep_last_ff;
      byte_in          = byte_ff;
      count_in         = count_ff;
      done_in          = done_ff;
      end_in           = end_ff;
      valid_in         = valid_ff && !rsp_tready;

      if (cmd.load_item) begin
         valid_in = 1'b1;
         for (int k = 0; k < SLOT_COUNT; k++) begin
            byte_in[k] = '0;
         end
         count_in = '0;
         done_in  = 1'b1;
         end_in   = last_in;
         if (expect_header_ff) begin
            if (in_byte[BYTE_W-1]) begin
               run_left_in      = RUN_W'(in_byte & LITERAL_MASK);
               literal_mode_in  = (run_left_in != '0);
               expect_header_in = (run_left_in == '0);
            end else begin
               run_left_in      = in_byte[RUN_W-1:0];
               literal_mode_in  = 1'b0;
               expect_header_in = 1'b0;
            end
         end else if (literal_mode_ff) begin
            byte_in[0]  = in_byte;
            count_in    = COUNT_W'(1);
            run_left_in = literal_left;
            if (literal_left == '0) begin
               literal_mode_in  = 1'b0;
               expect_header_in = 1'b1;
            end
         end else begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
               byte_in[k] = (RUN_W'(k) < item_take) ? in_byte : '0;
            end
            count_in         = COUNT_W'(item_take);
            done_in          = (run_left_ff <= PACK_RUN);
            end_in           = last_in && (run_left_ff <= PACK_RUN);
            left_in          = run_left_ff - item_take;
            rep_byte_in      = in_byte;
            rep_last_in      = last_in;
            run_left_in      = '0;
            literal_mode_in  = 1'b0;
            expect_header_in = 1'b1;
         end
         if (last_in) begin
            expect_header_in = 1'b1;
            literal_mode_in  = 1'b0;
            run_left_in      = '0;
         end
      end else if (cmd.load_chunk) begin
         valid_in = 1'b1;
         for (int k = 0; k < SLOT_COUNT; k++) begin
            byte_in[k] = (RUN_W'(k) < chunk_take) ? rep_byte_ff : '0;
         end
         count_in = COUNT_W'(chunk_take);
         done_in  = (left_ff <= PACK_RUN);
         end_in   = rep_last_ff && (left_ff <= PACK_RUN);
         left_in  = left_ff - chunk_take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_header_ff <= 1'b1;
         literal_mode_ff  <= 1'b0;
         run_left_ff      <= '0;
         valid_ff         <= 1'b0;
      end else begin
         expect_header_ff <= expect_header_in;
         literal_mode_ff  <= literal_mode_in;
         run_left_ff      <= run_left_in;
         valid_ff         <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff     <= left_in;
      rep_byte_ff <= rep_byte_in;
      rep_last_ff <= rep_last_in;
      byte_ff     <= byte_in;
      count_ff    <= count_in;
      done_ff     <= done_in;
      end_ff      <= end_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_bytes = byte_ff;
   assign rsp_count = count_ff;
   assign rsp_done  = done_ff;
   assign rsp_end   = end_ff;

endmodule
